>>> rtl/core/rmp_pkg.sv
// Shared widths, constants and register codes for the rotation motion profile.
// Used by rotation_motion_profile and the testbench; depends on nothing.
package rmp_pkg;

  // Field widths.
  localparam int ANGLE_W = 17;
  localparam int MS_W    = 16;
  localparam int SPEED_W = 24;
  localparam int RATE_W  = 24;

  // Products and scaled values.
  localparam int MS_PER_S  = 1000;
  localparam int MS_SCALE_W = $clog2(MS_PER_S);
  localparam int PROD_W    = SPEED_W + MS_W;
  localparam int HAVE_W    = SPEED_W + MS_SCALE_W;
  localparam int CIRCLE_DEG = 360;

  // Stream and register port widths.
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Register indexes, at byte address 4 * index.
  localparam reg_idx_t REG_TARGET_ANGLE = 3'd0;
  localparam reg_idx_t REG_TURN_CCW     = 3'd1;
  localparam reg_idx_t REG_MAX_SPEED    = 3'd2;
  localparam reg_idx_t REG_ACCEL_RATE   = 3'd3;
  localparam reg_idx_t REG_ACCEL_ON     = 3'd4;
  localparam reg_idx_t REG_DECEL_RATE   = 3'd5;
  localparam reg_idx_t REG_DECEL_ON     = 3'd6;

endpackage

>>> rtl/core/rmp_sermul.sv
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Uses no package; instantiated by rotation_motion_profile.
module rmp_sermul #(
  parameter int A_W = 24,
  parameter int B_W = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   mcand;
  logic [A_W:0]     sum;

  // Add the multiplicand into the upper half when the low bit is set.
  always_comb begin
    sum = {1'b0, prod[A_W+B_W-1:B_W]} + (prod[0] ? {1'b0, mcand} : {(A_W+1){1'b0}});
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Product register: the multiplier shifts out low while the sum shifts in high.
  always_ff @(posedge clk) begin
    if (start) begin
      prod  <= {{A_W{1'b0}}, b};
      mcand <= a;
    end else if (busy) begin
      prod <= {sum, prod[B_W-1:1]};
    end
  end

endmodule

>>> rtl/core/rmp_serdiv.sv
// Bit-serial restoring divider by a constant: one quotient bit per cycle.
// Uses no package; instantiated by rotation_motion_profile.
module rmp_serdiv #(
  parameter int NUM_W   = 40,
  parameter int DIV_VAL = 1000,
  parameter int REM_W   = $clog2(DIV_VAL)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  output logic             busy,
  output logic [NUM_W-1:0] quot,
  output logic [REM_W-1:0] rem
);

  // The top bits below the divisor give zero quotient bits and are preloaded.
  localparam int SKIP  = (REM_W - 1 < NUM_W - 1) ? REM_W - 1 : NUM_W - 1;
  localparam int ITER  = NUM_W - SKIP;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] r;
  logic [ITER-1:0]  q;
  logic [REM_W:0]   trial;
  logic             ge;

  // One restoring step: bring down the next bit and subtract when it fits.
  always_comb begin
    trial = {r, q[ITER-1]};
    ge    = (trial >= (REM_W+1)'(DIV_VAL));
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ITER);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Partial remainder and dividend/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      r <= REM_W'(dividend[NUM_W-1 -: SKIP]);
      q <= dividend[ITER-1:0];
    end else if (busy) begin
      r <= ge ? REM_W'(trial - (REM_W+1)'(DIV_VAL)) : REM_W'(trial);
      q <= (q << 1) | ITER'(ge);
    end
  end

  assign quot = NUM_W'(q);
  assign rem  = r;

endmodule

>>> rtl/core/rotation_motion_profile.sv
// Rotation motion profile: trapezoidal speed ramp toward a target angle.
// One item at a time; the time from accept to result is set by two or three
// serial multiplier waits and up to three divides by 1000.
// The next item is accepted the cycle after a result is posted; a finished result
// waits in the output register while the next item is worked on.
// Synchronous reset clears speed, braking, the sequencer and the registers to
// their defaults (direction counter-clockwise, deceleration 1).
// Depends on rmp_pkg, rmp_sermul and rmp_serdiv.
module rotation_motion_profile #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // Input items.
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // restart [0], elapsed_ms [16:1], current_angle [33:17], zero fill [39:34]
  input  logic [rmp_pkg::S_TDATA_W-1:0]    s_tdata,
  // Result items.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // new_angle [16:0], done_res [17], zero fill [23:18]
  output logic [rmp_pkg::M_TDATA_W-1:0]    m_tdata,
  // Register port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rmp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [rmp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [rmp_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int FULL_CIRCLE = rmp_pkg::CIRCLE_DEG << ANGLE_FRAC_BITS;
  localparam int AW          = $clog2(FULL_CIRCLE);
  localparam int SQ_W        = 2 * rmp_pkg::SPEED_W;
  localparam int RHS_W       = rmp_pkg::RATE_W + AW + 1;
  localparam int CMP_W       = (SQ_W > RHS_W) ? SQ_W : RHS_W;
  localparam int RK_W        = AW + rmp_pkg::MS_SCALE_W;
  localparam int NCMP_W      = (rmp_pkg::PROD_W > RK_W) ? rmp_pkg::PROD_W : RK_W;
  localparam int PW          = rmp_pkg::PROD_W;
  localparam int HW          = rmp_pkg::HAVE_W;
  localparam int SW          = rmp_pkg::SPEED_W;
  localparam int ANW         = rmp_pkg::ANGLE_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_MOD    = 12'b0000_0000_0010,
    S_LAUNCH = 12'b0000_0000_0100,
    S_MUL1   = 12'b0000_0000_1000,
    S_DIV1   = 12'b0000_0001_0000,
    S_CHK    = 12'b0000_0010_0000,
    S_SQ     = 12'b0000_0100_0000,
    S_DIV2   = 12'b0000_1000_0000,
    S_LNUM   = 12'b0001_0000_0000,
    S_MUL2   = 12'b0010_0000_0000,
    S_DIV3   = 12'b0100_0000_0000,
    S_OUT    = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [ANW-1:0]              target_angle;
  logic                        turn_ccw;
  logic [SW-1:0]               max_speed;
  logic [rmp_pkg::RATE_W-1:0]  accel_rate;
  logic                        accel_on;
  logic [rmp_pkg::RATE_W-1:0]  decel_rate;
  logic                        decel_on;

  // Motion state and per-item working registers.
  logic [SW-1:0]               speed;
  logic                        braking;
  logic [rmp_pkg::MS_W-1:0]    ms_r;
  logic [AW-1:0]               cur_r;
  logic [AW-1:0]               dest_r;
  logic [AW-1:0]               ang_r;
  logic                        fin;
  logic [ANW-1:0]              out_angle;
  logic                        out_done;

  // Input fields.
  logic                        in_restart;
  logic [rmp_pkg::MS_W-1:0]    in_ms;
  logic [ANW-1:0]              in_angle;
  logic                        accept;
  logic                        out_free;

  // Unit handshakes and results.
  logic                        mod_start, mod_busy;
  logic [AW-1:0]               cur_mod, dest_mod;
  logic                        m0_start, m12_start, m0_busy, m1_busy, m2_busy, mul_idle;
  logic [SW-1:0]               m0_a, m0_b;
  logic [SQ_W-1:0]             m0_prod;
  logic [PW-1:0]               m1_prod;
  logic [rmp_pkg::RATE_W+AW-1:0] m2_prod;
  logic                        dv_start, dv_busy;
  logic [PW-1:0]               dv_num, dq;

  // Datapath terms.
  logic [AW-1:0]               remain_c;
  logic [HW-1:0]               have_c, diff_c;
  logic [RK_W-1:0]             rk_c;
  logic [PW:0]                 sum_c;
  logic [SW-1:0]               clamp_c;
  logic                        brake_hit, drop_over, num_over, num_zero;
  logic [AW-1:0]               step_c, ang_c;
  logic [AW:0]                 pick_c;
  logic [rmp_pkg::REG_IDX_W-1:0] reg_idx;
  logic                        wr_en;

  assign in_restart = s_tdata[0];
  assign in_ms      = s_tdata[rmp_pkg::MS_W:1];
  assign in_angle   = s_tdata[rmp_pkg::MS_W+ANW:rmp_pkg::MS_W+1];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(rmp_pkg::M_TDATA_W-ANW-1){1'b0}}, out_done, out_angle};

  // Register port: writes complete in the access phase, reads are a plain mux.
  assign pready  = 1'b1;
  assign reg_idx = paddr[rmp_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_angle <= '0;
      turn_ccw     <= 1'b1;
      max_speed    <= '0;
      accel_rate   <= '0;
      accel_on     <= 1'b0;
      decel_rate   <= rmp_pkg::RATE_W'(1);
      decel_on     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        rmp_pkg::REG_TARGET_ANGLE: target_angle <= pwdata[ANW-1:0];
        rmp_pkg::REG_TURN_CCW:     turn_ccw     <= pwdata[0];
        rmp_pkg::REG_MAX_SPEED:    max_speed    <= pwdata[SW-1:0];
        rmp_pkg::REG_ACCEL_RATE:   accel_rate   <= pwdata[rmp_pkg::RATE_W-1:0];
        rmp_pkg::REG_ACCEL_ON:     accel_on     <= pwdata[0];
        rmp_pkg::REG_DECEL_RATE:   decel_rate   <= pwdata[rmp_pkg::RATE_W-1:0];
        rmp_pkg::REG_DECEL_ON:     decel_on     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rmp_pkg::REG_TARGET_ANGLE: prdata = rmp_pkg::APB_DATA_W'(target_angle);
      rmp_pkg::REG_TURN_CCW:     prdata = rmp_pkg::APB_DATA_W'(turn_ccw);
      rmp_pkg::REG_MAX_SPEED:    prdata = rmp_pkg::APB_DATA_W'(max_speed);
      rmp_pkg::REG_ACCEL_RATE:   prdata = rmp_pkg::APB_DATA_W'(accel_rate);
      rmp_pkg::REG_ACCEL_ON:     prdata = rmp_pkg::APB_DATA_W'(accel_on);
      rmp_pkg::REG_DECEL_RATE:   prdata = rmp_pkg::APB_DATA_W'(decel_rate);
      rmp_pkg::REG_DECEL_ON:     prdata = rmp_pkg::APB_DATA_W'(decel_on);
      default:                   prdata = '0;
    endcase
  end

  // Reduce the present angle and the target modulo a full circle.
  assign mod_start = accept;

  rmp_serdiv #(.NUM_W(ANW), .DIV_VAL(FULL_CIRCLE), .REM_W(AW)) u_cur_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(in_angle),
    .busy(mod_busy), .quot(), .rem(cur_mod)
  );

  rmp_serdiv #(.NUM_W(ANW), .DIV_VAL(FULL_CIRCLE), .REM_W(AW)) u_dest_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(target_angle),
    .busy(), .quot(), .rem(dest_mod)
  );

  // Angle still to travel in the configured direction.
  always_comb begin
    if (turn_ccw) begin
      remain_c = (dest_r >= cur_r) ? (dest_r - cur_r)
               : AW'({1'b0, dest_r} + (AW+1)'(FULL_CIRCLE) - {1'b0, cur_r});
    end else begin
      remain_c = (cur_r >= dest_r) ? (cur_r - dest_r)
               : AW'({1'b0, cur_r} + (AW+1)'(FULL_CIRCLE) - {1'b0, dest_r});
    end
  end

  // Shared multiplier: acceleration times ms, then speed squared (with deceleration on), then speed times ms.
  assign m0_start  = (state == S_LAUNCH) || (state == S_CHK) || (state == S_LNUM);
  assign m12_start = (state == S_LAUNCH);

  always_comb begin
    m0_a = speed;
    m0_b = SW'(ms_r);
    case (state)
      S_LAUNCH: m0_a = accel_rate;
      S_CHK:    m0_b = decel_on ? speed : SW'(ms_r);
      default: ;
    endcase
  end

  rmp_sermul #(.A_W(SW), .B_W(SW)) u_mul_main (
    .clk(clk), .rst(rst), .start(m0_start), .a(m0_a), .b(m0_b),
    .busy(m0_busy), .prod(m0_prod)
  );

  // Speed lost to braking over this tick, times 1000.
  rmp_sermul #(.A_W(rmp_pkg::RATE_W), .B_W(rmp_pkg::MS_W)) u_mul_drop (
    .clk(clk), .rst(rst), .start(m12_start), .a(decel_rate), .b(ms_r),
    .busy(m1_busy), .prod(m1_prod)
  );

  // Deceleration times remaining angle for the braking distance test.
  rmp_sermul #(.A_W(rmp_pkg::RATE_W), .B_W(AW)) u_mul_dist (
    .clk(clk), .rst(rst), .start(m12_start), .a(decel_rate), .b(remain_c),
    .busy(m2_busy), .prod(m2_prod)
  );

  assign mul_idle = !(m0_busy || m1_busy || m2_busy);

  // Constant scaling by 1000 as 1024 - 32 + 8.
  always_comb begin
    have_c = (HW'(speed) << 10) - (HW'(speed) << 5) + (HW'(speed) << 3);
    rk_c   = (RK_W'(remain_c) << 10) - (RK_W'(remain_c) << 5) + (RK_W'(remain_c) << 3);
    diff_c = have_c - HW'(m1_prod);
  end

  // Decisions taken from the multiplier results.
  always_comb begin
    brake_hit = CMP_W'(m0_prod) > CMP_W'({m2_prod, 1'b0});
    drop_over = m1_prod > PW'(have_c);
    num_over  = NCMP_W'(m0_prod[PW-1:0]) > NCMP_W'(rk_c);
    num_zero  = (m0_prod[PW-1:0] == '0);
  end

  // Divider by 1000, shared by the three scaled quotients.
  always_comb begin
    dv_start = 1'b0;
    dv_num   = m0_prod[PW-1:0];
    case (state)
      S_MUL1: dv_start = mul_idle && !braking && accel_on;
      S_SQ: begin
        dv_start = !m0_busy && brake_hit && !drop_over;
        dv_num   = PW'(diff_c);
      end
      S_MUL2: dv_start = !m0_busy && !num_over && !num_zero;
      default: ;
    endcase
  end

  rmp_serdiv #(.NUM_W(PW), .DIV_VAL(rmp_pkg::MS_PER_S), .REM_W(rmp_pkg::MS_SCALE_W)) u_div_ms (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_num),
    .busy(dv_busy), .quot(dq), .rem()
  );

  // Ramped speed clamped at the top speed.
  always_comb begin
    sum_c   = (PW+1)'(speed) + (PW+1)'(dq);
    clamp_c = (sum_c > (PW+1)'(max_speed)) ? max_speed : SW'(sum_c);
  end

  // Move the angle by the step and wrap to one circle.
  always_comb begin
    step_c = dq[AW-1:0];
    if (turn_ccw) begin
      pick_c = {1'b0, cur_r} + {1'b0, step_c};
    end else begin
      pick_c = {1'b0, cur_r} + (AW+1)'(FULL_CIRCLE) - {1'b0, step_c};
    end
    ang_c = (pick_c >= (AW+1)'(FULL_CIRCLE)) ? AW'(pick_c - (AW+1)'(FULL_CIRCLE))
                                             : AW'(pick_c);
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_tvalid) state_next = S_MOD;
      S_MOD:    if (!mod_busy) state_next = S_LAUNCH;
      S_LAUNCH: state_next = S_MUL1;
      S_MUL1: begin
        if (mul_idle) begin
          state_next = (!braking && accel_on) ? S_DIV1 : S_CHK;
        end
      end
      S_DIV1:   if (!dv_busy) state_next = S_CHK;
      S_CHK:    state_next = decel_on ? S_SQ : S_MUL2;
      S_SQ: begin
        if (!m0_busy) begin
          if (brake_hit) begin
            state_next = drop_over ? S_OUT : S_DIV2;
          end else begin
            state_next = S_LNUM;
          end
        end
      end
      S_DIV2:   if (!dv_busy) state_next = S_LNUM;
      S_LNUM:   state_next = S_MUL2;
      S_MUL2: begin
        if (!m0_busy) begin
          state_next = (num_over || num_zero) ? S_OUT : S_DIV3;
        end
      end
      S_DIV3:   if (!dv_busy) state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state: sequencer, speed, braking latch and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      speed    <= '0;
      braking  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // Post a finished item, or drop the valid once the item is taken.
      if (state == S_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && in_restart) begin
            speed   <= '0;
            braking <= 1'b0;
          end
        end
        S_MUL1: if (mul_idle && !braking && !accel_on) speed <= max_speed;
        S_DIV1: if (!dv_busy) speed <= clamp_c;
        S_SQ: begin
          if (!m0_busy && brake_hit) begin
            braking <= 1'b1;
            if (drop_over) begin
              speed <= '0;
            end
          end
        end
        S_DIV2: if (!dv_busy) speed <= dq[SW-1:0];
        default: ;
      endcase
    end
  end

  // Per-item payload registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ms_r <= in_ms;
          fin  <= 1'b0;
        end
      end
      S_MOD: begin
        if (!mod_busy) begin
          cur_r  <= cur_mod;
          dest_r <= dest_mod;
        end
      end
      S_SQ:   if (!m0_busy && brake_hit && drop_over) fin <= 1'b1;
      S_MUL2: if (!m0_busy && (num_over || num_zero)) fin <= 1'b1;
      S_DIV3: if (!dv_busy) ang_r <= ang_c;
      S_OUT: begin
        if (out_free) begin
          out_angle <= fin ? ANW'(dest_r) : ANW'(ang_r);
          out_done  <= fin;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for rotation_motion_profile: directed and random tick items,
// checked against a cycle-free predictor of the speed profile. Depends on rmp_pkg and the RTL.
module testbench;

  localparam int FRAC_BITS = 8;
  localparam logic [63:0] FULL_CIRCLE = 64'(rmp_pkg::CIRCLE_DEG << FRAC_BITS);
  localparam logic [rmp_pkg::ANGLE_W-1:0] LAST_ANGLE =
    rmp_pkg::ANGLE_W'(FULL_CIRCLE - 64'd1);
  localparam logic [63:0] MS_SCALE = 64'(rmp_pkg::MS_PER_S);
  localparam int RANDOM_TICKS = 1270;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [rmp_pkg::ANGLE_W-1:0] angle;
    logic                        done;
  } tick_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [rmp_pkg::S_TDATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [rmp_pkg::M_TDATA_W-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [rmp_pkg::APB_ADDR_W-1:0] paddr;
  logic [rmp_pkg::APB_DATA_W-1:0] pwdata;
  logic [rmp_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  // Predictor copy of the registers, at their reset values.
  logic [rmp_pkg::ANGLE_W-1:0] cfg_target = '0;
  logic                        cfg_turn_ccw = 1'b1;
  logic [rmp_pkg::SPEED_W-1:0] cfg_max_speed = '0;
  logic [rmp_pkg::RATE_W-1:0]  cfg_accel_rate = '0;
  logic                        cfg_accel_on = 1'b0;
  logic [rmp_pkg::RATE_W-1:0]  cfg_decel_rate = rmp_pkg::RATE_W'(1);
  logic                        cfg_decel_on = 1'b0;

  // Predictor copy of the motion state.
  logic [rmp_pkg::SPEED_W-1:0] motion_speed = '0;
  logic                        motion_braking = 1'b0;

  tick_result_t pending_angles[$];
  logic [rmp_pkg::ANGLE_W-1:0] last_angle = '0;
  logic                        last_done = 1'b0;

  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned failures = 0;
  int unsigned settings_applied = 0;
  int unsigned brake_ticks = 0;
  int unsigned done_ticks = 0;
  int unsigned longest_hold = 0;
  int unsigned hold_request = 0;
  logic feed_gaps = 1'b0;
  logic drain_stalls = 1'b0;

  rotation_motion_profile #(
    .ANGLE_FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results still outstanding", pending_angles.size());
    $display("Test completed with failures");
    $finish;
  end

  // One tick of the profile: updates the motion state and returns the expected result.
  function automatic tick_result_t advance_profile(input logic restart,
                                                   input logic [rmp_pkg::MS_W-1:0] ms,
                                                   input logic [rmp_pkg::ANGLE_W-1:0] angle);
    logic [63:0] cur, dest, remain, ms64, spd, sum, limit, accel, decel;
    logic [63:0] drop, have, num, step;
    logic done;
    tick_result_t res;
    ms64 = 64'(ms);
    cur = 64'(angle);
    cur = cur % FULL_CIRCLE;
    dest = 64'(cfg_target);
    dest = dest % FULL_CIRCLE;
    limit = 64'(cfg_max_speed);
    accel = 64'(cfg_accel_rate);
    decel = 64'(cfg_decel_rate);
    done = 1'b0;

    if (restart) begin
      motion_speed = '0;
      motion_braking = 1'b0;
    end
    spd = 64'(motion_speed);

    // Angle left to travel in the configured direction.
    if (cfg_turn_ccw) begin
      remain = (dest >= cur) ? dest - cur : dest + FULL_CIRCLE - cur;
    end else begin
      remain = (cur >= dest) ? cur - dest : cur + FULL_CIRCLE - dest;
    end

    // Ramp up unless braking has been latched.
    if (!motion_braking) begin
      if (cfg_accel_on) begin
        sum = spd + (accel * ms64) / MS_SCALE;
        spd = (sum > limit) ? limit : sum;
      end else begin
        spd = limit;
      end
    end

    // Braking once the stopping distance exceeds what is left.
    if (cfg_decel_on && (spd * spd > remain * 64'd2 * decel)) begin
      drop = decel * ms64;
      have = spd * MS_SCALE;
      motion_braking = 1'b1;
      brake_ticks++;
      if (drop > have) begin
        spd = '0;
        done = 1'b1;
      end else begin
        spd = (have - drop) / MS_SCALE;
      end
    end

    // Move, or snap to the target on overshoot or a zero step.
    if (!done) begin
      num = spd * ms64;
      if (num > remain * MS_SCALE || num == 64'd0) begin
        done = 1'b1;
      end else begin
        step = num / MS_SCALE;
        if (cfg_turn_ccw) begin
          cur = (cur + step) % FULL_CIRCLE;
        end else begin
          cur = (cur + FULL_CIRCLE - step) % FULL_CIRCLE;
        end
      end
    end

    motion_speed = spd[rmp_pkg::SPEED_W-1:0];
    if (done) done_ticks++;
    res.angle = done ? dest[rmp_pkg::ANGLE_W-1:0] : cur[rmp_pkg::ANGLE_W-1:0];
    res.done = done;
    return res;
  endfunction

  // Gap lengths: mostly short, a few long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 94) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [rmp_pkg::RATE_W-1:0] pick_rate();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 22) return rmp_pkg::RATE_W'($urandom);
    return rmp_pkg::RATE_W'($urandom_range(64, 1440 * 256));
  endfunction

  function automatic logic [rmp_pkg::ANGLE_W-1:0] pick_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return LAST_ANGLE;
    if (r < 20) begin
      return rmp_pkg::ANGLE_W'($urandom_range(32'(FULL_CIRCLE), (1 << rmp_pkg::ANGLE_W) - 1));
    end
    return rmp_pkg::ANGLE_W'($urandom_range(0, 32'(LAST_ANGLE)));
  endfunction

  function automatic logic [rmp_pkg::MS_W-1:0] pick_ms();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return rmp_pkg::MS_W'($urandom);
    return rmp_pkg::MS_W'($urandom_range(1, 100));
  endfunction

  // Register write: setup cycle, access cycle, then idle.
  task automatic write_reg(input rmp_pkg::reg_idx_t idx,
                           input logic [rmp_pkg::APB_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      rmp_pkg::REG_TARGET_ANGLE: cfg_target = value[rmp_pkg::ANGLE_W-1:0];
      rmp_pkg::REG_TURN_CCW:     cfg_turn_ccw = value[0];
      rmp_pkg::REG_MAX_SPEED:    cfg_max_speed = value[rmp_pkg::SPEED_W-1:0];
      rmp_pkg::REG_ACCEL_RATE:   cfg_accel_rate = value[rmp_pkg::RATE_W-1:0];
      rmp_pkg::REG_ACCEL_ON:     cfg_accel_on = value[0];
      rmp_pkg::REG_DECEL_RATE:   cfg_decel_rate = value[rmp_pkg::RATE_W-1:0];
      rmp_pkg::REG_DECEL_ON:     cfg_decel_on = value[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Full register setting; called only while the block is idle.
  task automatic set_profile(input logic [rmp_pkg::ANGLE_W-1:0] target, input logic ccw,
                             input logic [rmp_pkg::SPEED_W-1:0] vmax,
                             input logic [rmp_pkg::RATE_W-1:0] accel,
                             input logic accel_en, input logic [rmp_pkg::RATE_W-1:0] decel,
                             input logic decel_en);
    write_reg(rmp_pkg::REG_TARGET_ANGLE, rmp_pkg::APB_DATA_W'(target));
    write_reg(rmp_pkg::REG_TURN_CCW, rmp_pkg::APB_DATA_W'(ccw));
    write_reg(rmp_pkg::REG_MAX_SPEED, rmp_pkg::APB_DATA_W'(vmax));
    write_reg(rmp_pkg::REG_ACCEL_RATE, rmp_pkg::APB_DATA_W'(accel));
    write_reg(rmp_pkg::REG_ACCEL_ON, rmp_pkg::APB_DATA_W'(accel_en));
    write_reg(rmp_pkg::REG_DECEL_RATE, rmp_pkg::APB_DATA_W'(decel));
    write_reg(rmp_pkg::REG_DECEL_ON, rmp_pkg::APB_DATA_W'(decel_en));
    settings_applied++;
  endtask

  // Offers one tick item, records its expected result once accepted, then maybe idles.
  task automatic send_tick(input logic restart, input logic [rmp_pkg::MS_W-1:0] ms,
                           input logic [rmp_pkg::ANGLE_W-1:0] angle);
    tick_result_t res;
    int unsigned gap;
    s_tdata <= {{(rmp_pkg::S_TDATA_W - 1 - rmp_pkg::MS_W - rmp_pkg::ANGLE_W){1'b0}},
                angle, ms, restart};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    res = advance_profile(restart, ms, angle);
    pending_angles.push_back(res);
    last_angle = res.angle;
    last_done = res.done;
    ticks_sent++;
    if (feed_gaps && $urandom_range(0, 99) < 35) begin
      gap = gap_len();
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Next tick of a motion sequence, starting from the last predicted angle.
  task automatic motion_tick(input logic restart, input logic [rmp_pkg::MS_W-1:0] ms);
    send_tick(restart, ms, last_angle);
  endtask

  // Stops offering items and waits for every outstanding result.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  initial begin : result_sink
    int unsigned n;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        if (n > longest_hold) longest_hold = n;
      end else if (drain_stalls && $urandom_range(0, 99) < 30) begin
        n = gap_len();
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  task automatic note_failure(input string what, input tick_result_t want,
                              input tick_result_t got);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("%0t: %s: expected angle %0d done %0d, got angle %0d done %0d",
               $realtime, what, want.angle, want.done, got.angle, got.done);
    end
  endtask

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin : check_result
    tick_result_t got;
    tick_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.angle = m_tdata[rmp_pkg::ANGLE_W-1:0];
      got.done = m_tdata[rmp_pkg::ANGLE_W];
      results_seen++;
      if (pending_angles.size() == 0) begin
        want = '0;
        note_failure("result with no tick outstanding", want, got);
      end else begin
        want = pending_angles.pop_front();
        if (got.angle != want.angle) note_failure("new_angle mismatch", want, got);
        else if (got.done != want.done) note_failure("done mismatch", want, got);
      end
    end
  end

  // Register defaults: zero top speed gives done at target 0.
  task automatic test_reset_defaults();
    send_tick(1'b0, 16'd20, 17'd12345);
    send_tick(1'b1, '1, '1);
    drain();
  endtask

  // Ramp, cruise and braking toward 90 degrees counter-clockwise.
  task automatic test_ramp_and_brake();
    int unsigned i;
    set_profile(17'd23040, 1'b1, 24'd23040, 24'd46080, 1'b1, 24'd46080, 1'b1);
    send_tick(1'b1, 16'd200, '0);
    i = 0;
    while (i < 11 && !last_done) begin
      motion_tick(1'b0, 16'd200);
      i++;
    end
    drain();
  endtask

  // Field and register extremes, clockwise, acceleration off, braking below zero.
  task automatic test_field_extremes();
    set_profile('1, 1'b0, '1, '1, 1'b0, '1, 1'b1);
    send_tick(1'b1, 16'd0, '1);
    send_tick(1'b0, '1, LAST_ANGLE);
    send_tick(1'b0, 16'd1, '0);
    send_tick(1'b1, 16'd1, '0);
    drain();
    // Speed would go negative within one tick.
    set_profile(17'd1000, 1'b1, 24'd256, '0, 1'b0, 24'd10, 1'b1);
    send_tick(1'b1, '1, '0);
    send_tick(1'b0, 16'd1, '0);
    drain();
  endtask

  // Zero deceleration brakes at any speed without slowing.
  task automatic test_zero_decel();
    set_profile(17'd46080, 1'b0, 24'd2560, '0, 1'b0, '0, 1'b1);
    send_tick(1'b1, 16'd100, '0);
    motion_tick(1'b0, 16'd100);
    motion_tick(1'b0, 16'd3000);
    drain();
  endtask

  // Long output hold-off while the input keeps offering items back to back.
  task automatic test_output_backpressure();
    int unsigned i;
    set_profile(17'd60000, 1'b1, 24'd92160, 24'd23040, 1'b1, 24'd46080, 1'b1);
    feed_gaps = 1'b0;
    hold_request = 400;
    send_tick(1'b1, 16'd40, 17'd100);
    for (i = 0; i < 7; i++) motion_tick(1'b0, 16'd40);
    drain();
  endtask

  // Random register settings; mostly closed-loop motion sequences, some noise.
  task automatic test_random_profiles(input int unsigned budget);
    int unsigned done_count, phase_end, i, r;
    logic [rmp_pkg::ANGLE_W-1:0] start;
    done_count = 0;
    while (done_count < budget) begin
      set_profile(pick_target(), 1'($urandom_range(0, 1)), pick_rate(), pick_rate(),
                  1'($urandom_range(0, 1)), pick_rate(), ($urandom_range(0, 3) != 0));
      feed_gaps = ($urandom_range(0, 3) != 0);
      drain_stalls = ($urandom_range(0, 3) != 0);
      phase_end = done_count + $urandom_range(80, 120);
      while (done_count < phase_end && done_count < budget) begin
        if ($urandom_range(0, 99) < 75) begin
          // Motion sequence from a fresh start until the target is reached.
          start = ($urandom_range(0, 9) == 0) ? rmp_pkg::ANGLE_W'($urandom)
                : rmp_pkg::ANGLE_W'($urandom_range(0, 32'(LAST_ANGLE)));
          send_tick(1'b1, pick_ms(), start);
          done_count++;
          i = 0;
          while (!last_done && i < 40) begin
            r = $urandom_range(0, 99);
            if (r < 3) send_tick(1'b0, pick_ms(), rmp_pkg::ANGLE_W'($urandom));
            else if (r < 5) motion_tick(1'b1, pick_ms());
            else motion_tick(1'b0, pick_ms());
            done_count++;
            i++;
          end
        end else begin
          send_tick(1'($urandom_range(0, 1)), rmp_pkg::MS_W'($urandom),
                    rmp_pkg::ANGLE_W'($urandom));
          done_count++;
        end
      end
      drain();
    end
  endtask

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_ramp_and_brake();
    test_field_extremes();
    test_zero_decel();
    test_output_backpressure();
    test_random_profiles(RANDOM_TICKS);

    drain();
    repeat (200) @(posedge clk);
    $display("Checked %0d results from %0d ticks over %0d register settings.",
             results_seen, ticks_sent, settings_applied);
    $display("%0d ticks braked, %0d reached the target; longest output hold-off %0d cycles.",
             brake_ticks, done_ticks, longest_hold);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d failures", failures);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
